// ===== rtl/core/zpg_pkg.sv =====
// zpg_pkg: shared widths, register codes, coefficient and divider word types
// and the sine table for the zone plate pattern generator
// no dependencies
package zpg_pkg;

  localparam int MAX_DIMENSION = 4096;

  // field widths
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int DIM_W      = $clog2(MAX_DIMENSION + 1);
  localparam int COORD_W    = 12;
  localparam int FRAME_W    = 16;
  localparam int RATE_W     = 8;
  localparam int SHIFT_W    = 12;
  localparam int PIX_W      = 10;
  localparam int PHASE_W    = 8;

  // internal widths
  localparam int MAG_W  = 12;             // folded, centred magnitude
  localparam int SQ_W   = 2 * MAG_W;      // square of the magnitude
  localparam int QX_W   = 15;             // 65535 / width
  localparam int KY_W   = 19;             // (128 * height) / width
  localparam int KR_W   = 12;             // remainder below height
  localparam int XLO_W  = 17;             // product bits that reach the x term
  localparam int PK_W   = KR_W + SQ_W;    // remainder times y squared

  // per-pixel long division of PK by height
  localparam int DIV_QUOT_BITS       = SQ_W;
  localparam int DIV_STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES          = DIV_QUOT_BITS / DIV_STEPS_PER_STAGE;

  // shared serial divider for the coefficients
  localparam int CO_NUM_W  = 20;
  localparam int CO_STEPS  = CO_NUM_W;
  localparam int CO_CNT_W  = $clog2(CO_STEPS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_RATE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_SHIFT_Y = 3'd4;

  // reset values
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 13'd1920;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 13'd1080;
  localparam logic [RATE_W-1:0]     TIME_RATE_RESET    = 8'd1;
  localparam logic [SHIFT_W-1:0]    SHIFT_RESET        = 12'd0;

  localparam logic [CO_NUM_W-1:0] X_NUMERATOR = 20'hFFFF;
  localparam logic [PIX_W-1:0]    CHROMA_GREY = 10'h200;

  typedef struct packed {
    logic [DIM_W-1:0] wc;
    logic [DIM_W-1:0] hc;
    logic [QX_W-1:0]  qx;
    logic [7:0]       kq;
    logic [KR_W-1:0]  kr;
  } coeff_t;

  typedef struct packed {
    logic [KR_W-1:0]          rem;
    logic [DIV_QUOT_BITS-1:0] dividend;
    logic [PHASE_W-1:0]       quot;
    logic [PHASE_W-1:0]       acc;
  } div_word_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d < CFG_DATA_W'(2)) r = DIM_W'(2);
    else if (d > CFG_DATA_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    else r = DIM_W'(d);
    return r;
  endfunction

  localparam logic [7:0] SINE_LUT [0:255] = '{
    8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
    8'd152, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
    8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd191, 8'd193, 8'd196,
    8'd199, 8'd201, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd216,
    8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
    8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242, 8'd243, 8'd245,
    8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd252,
    8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254,
    8'd253, 8'd252, 8'd252, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247,
    8'd246, 8'd245, 8'd243, 8'd242, 8'd240, 8'd239, 8'd237, 8'd236,
    8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
    8'd218, 8'd216, 8'd213, 8'd211, 8'd209, 8'd206, 8'd204, 8'd201,
    8'd199, 8'd196, 8'd193, 8'd191, 8'd188, 8'd185, 8'd182, 8'd179,
    8'd176, 8'd174, 8'd171, 8'd168, 8'd165, 8'd162, 8'd159, 8'd156,
    8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
    8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
    8'd103, 8'd99,  8'd96,  8'd93,  8'd90,  8'd87,  8'd84,  8'd81,
    8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd64,  8'd62,  8'd59,
    8'd56,  8'd54,  8'd51,  8'd49,  8'd46,  8'd44,  8'd42,  8'd39,
    8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
    8'd21,  8'd19,  8'd18,  8'd16,  8'd15,  8'd13,  8'd12,  8'd10,
    8'd9,   8'd8,   8'd7,   8'd6,   8'd5,   8'd4,   8'd3,   8'd3,
    8'd2,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
    8'd2,   8'd3,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,
    8'd9,   8'd10,  8'd12,  8'd13,  8'd15,  8'd16,  8'd18,  8'd19,
    8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
    8'd37,  8'd39,  8'd42,  8'd44,  8'd46,  8'd49,  8'd51,  8'd54,
    8'd56,  8'd59,  8'd62,  8'd64,  8'd67,  8'd70,  8'd73,  8'd76,
    8'd79,  8'd81,  8'd84,  8'd87,  8'd90,  8'd93,  8'd96,  8'd99,
    8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
  };

endpackage

// ===== rtl/core/zpg_coeff.sv =====
// zpg_coeff: clamps the picture size and works out the per-picture
// coefficients with one shared bit-serial divider; uses zpg_pkg
module zpg_coeff (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [zpg_pkg::CFG_DATA_W-1:0]     frame_width,
  input  logic [zpg_pkg::CFG_DATA_W-1:0]     frame_height,
  input  logic                               recalc,
  output logic                               busy,
  output zpg_pkg::coeff_t                    coeff
);

  typedef enum logic [7:0] {
    ST_PREP   = 8'b0000_0001,
    ST_LOAD_X = 8'b0000_0010,
    ST_DIV_X  = 8'b0000_0100,
    ST_LOAD_K = 8'b0000_1000,
    ST_DIV_K  = 8'b0001_0000,
    ST_LOAD_Q = 8'b0010_0000,
    ST_DIV_Q  = 8'b0100_0000,
    ST_IDLE   = 8'b1000_0000
  } co_state_t;

  co_state_t                      state;
  logic [zpg_pkg::CO_CNT_W-1:0]   cnt;
  logic [zpg_pkg::CO_NUM_W-1:0]   num;
  logic [zpg_pkg::DIM_W-1:0]      den;
  logic [zpg_pkg::KR_W-1:0]       rem;
  logic [zpg_pkg::CO_NUM_W-1:0]   quot;
  logic [zpg_pkg::DIM_W-1:0]      wc;
  logic [zpg_pkg::DIM_W-1:0]      hc;
  logic [zpg_pkg::QX_W-1:0]       qx;
  logic [zpg_pkg::KY_W-1:0]       ky2;
  logic [7:0]                     kq;
  logic [zpg_pkg::KR_W-1:0]       kr;

  logic [zpg_pkg::KR_W:0]         rem_sh;
  logic                           ge;
  logic [zpg_pkg::KR_W-1:0]       rem_next;
  logic [zpg_pkg::CO_NUM_W-1:0]   quot_next;
  logic                           last_step;

  // one restoring step: remainder stays below the divisor
  always_comb begin
    rem_sh    = {rem, num[zpg_pkg::CO_NUM_W-1]};
    ge        = ({1'b0, rem_sh} >= {1'b0, den});
    rem_next  = ge ? zpg_pkg::KR_W'(rem_sh - den) : rem_sh[zpg_pkg::KR_W-1:0];
    quot_next = {quot[zpg_pkg::CO_NUM_W-2:0], ge};
    last_step = (cnt == zpg_pkg::CO_CNT_W'(zpg_pkg::CO_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    wc <= zpg_pkg::clamp_dim(frame_width);
    hc <= zpg_pkg::clamp_dim(frame_height);
    if (rst || recalc) begin
      state <= ST_PREP;
      cnt   <= '0;
    end else begin
      case (state)
        ST_PREP: begin
          state <= ST_LOAD_X;
        end
        ST_LOAD_X: begin
          num   <= zpg_pkg::X_NUMERATOR;
          den   <= wc;
          rem   <= '0;
          quot  <= '0;
          cnt   <= '0;
          state <= ST_DIV_X;
        end
        ST_DIV_X: begin
          num  <= num << 1;
          rem  <= rem_next;
          quot <= quot_next;
          cnt  <= cnt + 1'b1;
          if (last_step) begin
            qx    <= quot_next[zpg_pkg::QX_W-1:0];
            state <= ST_LOAD_K;
          end
        end
        ST_LOAD_K: begin
          num   <= zpg_pkg::CO_NUM_W'({hc, 7'b0});
          den   <= wc;
          rem   <= '0;
          quot  <= '0;
          cnt   <= '0;
          state <= ST_DIV_K;
        end
        ST_DIV_K: begin
          num  <= num << 1;
          rem  <= rem_next;
          quot <= quot_next;
          cnt  <= cnt + 1'b1;
          if (last_step) begin
            ky2   <= quot_next[zpg_pkg::KY_W-1:0];
            state <= ST_LOAD_Q;
          end
        end
        ST_LOAD_Q: begin
          num   <= zpg_pkg::CO_NUM_W'(ky2);
          den   <= hc;
          rem   <= '0;
          quot  <= '0;
          cnt   <= '0;
          state <= ST_DIV_Q;
        end
        ST_DIV_Q: begin
          num  <= num << 1;
          rem  <= rem_next;
          quot <= quot_next;
          cnt  <= cnt + 1'b1;
          if (last_step) begin
            kq    <= quot_next[7:0];
            kr    <= rem_next;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_PREP;
        end
      endcase
    end
  end

  assign busy     = (state != ST_IDLE);
  assign coeff.wc = wc;
  assign coeff.hc = hc;
  assign coeff.qx = qx;
  assign coeff.kq = kq;
  assign coeff.kr = kr;

endmodule

// ===== rtl/core/zpg_front.sv =====
// zpg_front: five pipeline stages from pixel position to the x term, the
// partial y and time terms and the dividend for the y division; uses zpg_pkg
module zpg_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [zpg_pkg::COORD_W-1:0]      column,
  input  logic [zpg_pkg::COORD_W-1:0]      line_index,
  input  logic [zpg_pkg::FRAME_W-1:0]      frame_count,
  input  zpg_pkg::coeff_t                  coeff,
  input  logic [zpg_pkg::RATE_W-1:0]       time_rate,
  input  logic [zpg_pkg::SHIFT_W-1:0]      centre_shift_x,
  input  logic [zpg_pkg::SHIFT_W-1:0]      centre_shift_y,
  output logic                             out_valid,
  input  logic                             out_ready,
  output zpg_pkg::div_word_t               out_word
);

  localparam int V_W = zpg_pkg::MAG_W + 2;

  // fold onto the first half, with the coordinate saturated to the picture
  function automatic logic [zpg_pkg::COORD_W-1:0] fold(
    input logic [zpg_pkg::COORD_W-1:0] c,
    input logic [zpg_pkg::DIM_W-1:0]   dim
  );
    logic [zpg_pkg::DIM_W-1:0] last;
    logic [zpg_pkg::DIM_W-1:0] cc;
    logic [zpg_pkg::DIM_W-1:0] half;
    last = dim - 1'b1;
    cc   = (zpg_pkg::DIM_W'(c) > last) ? last : zpg_pkg::DIM_W'(c);
    half = dim >> 1;
    return (cc < half) ? zpg_pkg::COORD_W'(cc) : zpg_pkg::COORD_W'(last - cc);
  endfunction

  // centre, offset and take the magnitude
  function automatic logic [zpg_pkg::MAG_W-1:0] centre_mag(
    input logic [zpg_pkg::COORD_W-1:0] idx,
    input logic [zpg_pkg::DIM_W-1:0]   dim,
    input logic [zpg_pkg::SHIFT_W-1:0] shift
  );
    logic [V_W-1:0] v;
    v = V_W'(idx) - V_W'(dim >> 1)
      - {{(V_W - zpg_pkg::SHIFT_W){shift[zpg_pkg::SHIFT_W-1]}}, shift};
    if (v[V_W-1]) v = -v;
    return v[zpg_pkg::MAG_W-1:0];
  endfunction

  logic a_en, b_en, c_en, d_en, e_en;
  logic a_v, b_v, c_v, d_v, e_v;

  logic [zpg_pkg::COORD_W-1:0]  a_ix, a_iy;
  logic [zpg_pkg::PHASE_W-1:0]  a_t, b_t, c_t, d_t;
  logic [zpg_pkg::MAG_W-1:0]    b_mx, b_my;
  logic [zpg_pkg::SQ_W-1:0]     c_xx, c_yy;
  logic [zpg_pkg::PHASE_W-1:0]  d_xt, d_pq;
  logic [zpg_pkg::PK_W-1:0]     d_pk;
  zpg_pkg::div_word_t           e_word;

  logic [2*zpg_pkg::RATE_W-1:0]               t_full;
  logic [zpg_pkg::QX_W+zpg_pkg::XLO_W-1:0]    px_full;
  logic [2*zpg_pkg::PHASE_W-1:0]              pq_full;

  assign e_en = !e_v || out_ready;
  assign d_en = !d_v || e_en;
  assign c_en = !c_v || d_en;
  assign b_en = !b_v || c_en;
  assign a_en = !a_v || b_en;
  assign in_ready = a_en;

  assign t_full  = time_rate * frame_count[zpg_pkg::RATE_W-1:0];
  assign px_full = coeff.qx * c_xx[zpg_pkg::XLO_W-1:0];
  assign pq_full = coeff.kq * c_yy[zpg_pkg::PHASE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else begin
      if (a_en) a_v <= in_valid;
      if (b_en) b_v <= a_v;
      if (c_en) c_v <= b_v;
      if (d_en) d_v <= c_v;
      if (e_en) e_v <= d_v;
    end
    if (a_en) begin
      a_ix <= fold(column, coeff.wc);
      a_iy <= fold(line_index, coeff.hc);
      a_t  <= t_full[zpg_pkg::PHASE_W-1:0];
    end
    if (b_en) begin
      b_mx <= centre_mag(a_ix, coeff.wc, centre_shift_x);
      b_my <= centre_mag(a_iy, coeff.hc, centre_shift_y);
      b_t  <= a_t;
    end
    if (c_en) begin
      c_xx <= b_mx * b_mx;
      c_yy <= b_my * b_my;
      c_t  <= b_t;
    end
    if (d_en) begin
      // bits 16..23 of 128*qx*xx are bits 9..16 of qx*xx
      d_xt <= px_full[zpg_pkg::XLO_W-1:zpg_pkg::XLO_W-zpg_pkg::PHASE_W];
      d_pq <= pq_full[zpg_pkg::PHASE_W-1:0];
      d_pk <= coeff.kr * c_yy;
      d_t  <= c_t;
    end
    if (e_en) begin
      e_word.acc      <= d_xt + d_pq + d_t;
      e_word.rem      <= d_pk[zpg_pkg::PK_W-1:zpg_pkg::DIV_QUOT_BITS];
      e_word.dividend <= d_pk[zpg_pkg::DIV_QUOT_BITS-1:0];
      e_word.quot     <= '0;
    end
  end

  assign out_valid = e_v;
  assign out_word  = e_word;

endmodule

// ===== rtl/core/zpg_div_stage.sv =====
// zpg_div_stage: one register stage of the long division by the picture
// height, four quotient bits per stage; uses zpg_pkg
module zpg_div_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [zpg_pkg::DIM_W-1:0]   divisor,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  zpg_pkg::div_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output zpg_pkg::div_word_t          out_word
);

  logic               v;
  zpg_pkg::div_word_t word;
  zpg_pkg::div_word_t word_next;
  logic               en;

  always_comb begin
    logic [zpg_pkg::KR_W:0] sh;
    logic                   ge;
    word_next = in_word;
    for (int k = 0; k < zpg_pkg::DIV_STEPS_PER_STAGE; k++) begin
      sh = {word_next.rem, word_next.dividend[zpg_pkg::DIV_QUOT_BITS-1]};
      ge = ({1'b0, sh} >= {1'b0, divisor});
      word_next.dividend = word_next.dividend << 1;
      word_next.rem  = ge ? zpg_pkg::KR_W'(sh - divisor) : sh[zpg_pkg::KR_W-1:0];
      word_next.quot = {word_next.quot[zpg_pkg::PHASE_W-2:0], ge};
    end
  end

  assign en       = !v || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
    if (en) word <= word_next;
  end

  assign out_valid = v;
  assign out_word  = word;

endmodule

// ===== rtl/core/zpg_out.sv =====
// zpg_out: final phase sum, sine table look-up and the output register
// uses zpg_pkg
module zpg_out (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  zpg_pkg::div_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [zpg_pkg::PIX_W-1:0]   luma
);

  logic                          v;
  logic                          en;
  logic [zpg_pkg::PHASE_W-1:0]   phase;

  assign phase    = in_word.acc + in_word.quot;
  assign en       = !v || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
    if (en) luma <= {zpg_pkg::SINE_LUT[phase], 2'b00};
  end

  assign out_valid = v;

endmodule

// ===== rtl/core/zone_plate_pattern_generator.sv =====
// zone_plate_pattern_generator: top level, configuration registers and the
// pixel pipeline; uses zpg_pkg, zpg_coeff, zpg_front, zpg_div_stage, zpg_out
//
// one pixel of a moving elliptical zone plate per input word: column and line
// are folded onto the top-left quadrant, centred and offset, squared, and the
// phase x term + y term + time_rate*frame_count picks a sine value that comes
// out as luma (sine*4) with chroma held at neutral grey. a new word is taken
// every clock and a result leaves every clock when nothing stalls. a word passes
// 5 front stages, 6 stages of the y-term division by the height, 4 quotient
// bits each, and the look-up/output register. every stage has its own valid
// bit and holds when the stage after it is full, so a stall at the output only
// backs up as far as it has to. the picture-size coefficients (65535/width,
// 128*height/width and its split by height) come from one bit-serial divider;
// in_ready stays low while it runs after reset and after each write of
// frame_width or frame_height. cfg_ready is always high.
module zone_plate_pattern_generator (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [zpg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [zpg_pkg::CFG_DATA_W-1:0]   cfg_data,
  // pixel position words
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [zpg_pkg::COORD_W-1:0]      column,
  input  logic [zpg_pkg::COORD_W-1:0]      line_index,
  input  logic [zpg_pkg::FRAME_W-1:0]      frame_count,
  // pixel words
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [zpg_pkg::PIX_W-1:0]        luma,
  output logic [zpg_pkg::PIX_W-1:0]        chroma
);

  // configuration registers
  logic [zpg_pkg::CFG_DATA_W-1:0] frame_width;
  logic [zpg_pkg::CFG_DATA_W-1:0] frame_height;
  logic [zpg_pkg::RATE_W-1:0]     time_rate;
  logic [zpg_pkg::SHIFT_W-1:0]    centre_shift_x;
  logic [zpg_pkg::SHIFT_W-1:0]    centre_shift_y;

  logic                           cfg_write;
  logic                           recalc;
  logic                           busy;
  zpg_pkg::coeff_t                coeff;

  logic                           front_ready;

  // division chain, one more slot than stages
  logic                           chain_valid [zpg_pkg::DIV_STAGES+1];
  logic                           chain_ready [zpg_pkg::DIV_STAGES+1];
  zpg_pkg::div_word_t             chain_word  [zpg_pkg::DIV_STAGES+1];

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // a new picture size means new coefficients
  assign recalc = cfg_write &&
                  ((cfg_index == zpg_pkg::REG_FRAME_WIDTH) ||
                   (cfg_index == zpg_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= zpg_pkg::FRAME_WIDTH_RESET;
      frame_height   <= zpg_pkg::FRAME_HEIGHT_RESET;
      time_rate      <= zpg_pkg::TIME_RATE_RESET;
      centre_shift_x <= zpg_pkg::SHIFT_RESET;
      centre_shift_y <= zpg_pkg::SHIFT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        zpg_pkg::REG_FRAME_WIDTH:    frame_width    <= cfg_data;
        zpg_pkg::REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        zpg_pkg::REG_TIME_RATE:      time_rate      <= cfg_data[zpg_pkg::RATE_W-1:0];
        zpg_pkg::REG_CENTRE_SHIFT_X: centre_shift_x <= cfg_data[zpg_pkg::SHIFT_W-1:0];
        zpg_pkg::REG_CENTRE_SHIFT_Y: centre_shift_y <= cfg_data[zpg_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // per-picture coefficients
  zpg_coeff u_coeff (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .recalc       (recalc),
    .busy         (busy),
    .coeff        (coeff)
  );

  // input is held off while the coefficients are being worked out
  assign in_ready = front_ready && !busy;

  zpg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid && !busy),
    .in_ready       (front_ready),
    .column         (column),
    .line_index     (line_index),
    .frame_count    (frame_count),
    .coeff          (coeff),
    .time_rate      (time_rate),
    .centre_shift_x (centre_shift_x),
    .centre_shift_y (centre_shift_y),
    .out_valid      (chain_valid[0]),
    .out_ready      (chain_ready[0]),
    .out_word       (chain_word[0])
  );

  // y term: floor(kr*yy / height), low quotient bits, four bits per stage
  for (genvar g = 0; g < zpg_pkg::DIV_STAGES; g++) begin : g_div
    zpg_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .divisor   (coeff.hc),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_word   (chain_word[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_word  (chain_word[g+1])
    );
  end

  zpg_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[zpg_pkg::DIV_STAGES]),
    .in_ready  (chain_ready[zpg_pkg::DIV_STAGES]),
    .in_word   (chain_word[zpg_pkg::DIV_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .luma      (luma)
  );

  // chroma never changes
  assign chroma = zpg_pkg::CHROMA_GREY;

endmodule
